### src/pts_pkg.sv
// Shared types, request codes and move-rate tables for the preset tour sequencer.
package pts_pkg;

   // Request codes carried in req_type; the remaining codes are ignored
   typedef enum logic [2:0] {
      REQ_WRITE_STEP = 3'd0,
      REQ_SET_LENGTH = 3'd1,
      REQ_START      = 3'd2,
      REQ_STOP       = 3'd3,
      REQ_TICK       = 3'd4
   } pts_req_code_type;

   // Loop modes; the unused code behaves as forward wrap
   localparam logic [1:0] MODE_ONCE     = 2'd0;
   localparam logic [1:0] MODE_WRAP     = 2'd1;
   localparam logic [1:0] MODE_PINGPONG = 2'd2;

   localparam logic [1:0] LOOP_MODE_RESET = MODE_WRAP;

   localparam logic [15:0] SEC_MAX = 16'hFFFF;

   // Speed codes
   localparam logic [1:0] SPEED_SLOW    = 2'd0;
   localparam logic [1:0] SPEED_MEDIUM  = 2'd1;
   localparam logic [1:0] SPEED_FAST    = 2'd2;
   localparam logic [1:0] SPEED_INSTANT = 2'd3;

   // Per-transaction view of the tour state that goes to the result port
   typedef struct packed {
      logic        trigger;
      logic        status;
      logic        running;
      logic [3:0]  current_step;
      logic [15:0] elapsed_s;
   } pts_tour_state_type;

   // Axis rates in degrees per second for a speed code
   function automatic logic [5:0] pts_roll_rate(input logic [1:0] speed);
      logic [5:0] rate;
      case (speed)
         SPEED_SLOW:   rate = 6'd10;
         SPEED_MEDIUM: rate = 6'd30;
         SPEED_FAST:   rate = 6'd60;
         default:      rate = 6'd0;
      endcase
      return rate;
   endfunction

   function automatic logic [6:0] pts_pitch_rate(input logic [1:0] speed);
      logic [6:0] rate;
      case (speed)
         SPEED_SLOW:   rate = 7'd15;
         SPEED_MEDIUM: rate = 7'd40;
         SPEED_FAST:   rate = 7'd80;
         default:      rate = 7'd0;
      endcase
      return rate;
   endfunction

   function automatic logic [6:0] pts_yaw_rate(input logic [1:0] speed);
      logic [6:0] rate;
      case (speed)
         SPEED_SLOW:   rate = 7'd20;
         SPEED_MEDIUM: rate = 7'd60;
         SPEED_FAST:   rate = 7'd120;
         default:      rate = 7'd0;
      endcase
      return rate;
   endfunction

endpackage

### src/preset_tour_sequencer_core.sv
// Top level of the preset tour sequencer: handshakes, loop-mode register and result port.
//
// Usage:
//   Request channel (req_*): write a step entry, set the list length, start,
//   stop, or deliver a one-second tick. A transaction is taken at a rising
//   edge with req_valid high and req_stall low.
//   Result channel (rsp_*): exactly one result per request transaction, in
//   order, taken at an edge with rsp_valid high and rsp_stall low.
//   Configuration channel (csr_*): writes the loop mode; csr_ready is always
//   high. Write it only while no request is outstanding.
//   Latency: the result is valid in the cycle after the request is taken.
//   Throughput: one transaction per cycle while req_stall is low; index,
//   counter and the step table read all update in that single cycle.
//   Stall: a result waiting under rsp_stall holds, and req_stall is raised
//   only while that result is held, so the result register is the one buffer.
//   Reset: tour stopped, list empty, pointer and counter zero, loop mode
//   forward wrap. Step entries are undefined until written.
module preset_tour_sequencer_core #(
   parameter int MAX_STEPS  = 16,
   parameter int DWELL_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [3:0]  req_step_index,
   input  logic [7:0]  req_preset_num,
   input  logic [15:0] req_dwell_seconds,
   input  logic [1:0]  req_move_speed,
   input  logic [4:0]  req_step_count,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_trigger,
   output logic [7:0]  rsp_trig_preset,
   output logic [1:0]  rsp_trig_speed,
   output logic [5:0]  rsp_roll_rate,
   output logic [6:0]  rsp_pitch_rate,
   output logic [6:0]  rsp_yaw_rate,
   output logic        rsp_running,
   output logic [3:0]  rsp_current_step,
   output logic [15:0] rsp_elapsed_s,
   output logic [15:0] rsp_total_s,
   output logic        rsp_status,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_loop_mode
);
   import pts_pkg::*;

   localparam int AW = $clog2(MAX_STEPS);
   localparam int LW = $clog2(MAX_STEPS + 1);

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            loop_mode_ff, loop_mode_in;
   logic                  req_accept;
   logic                  wr_en;
   logic [AW-1:0]         rd_addr;
   logic [7:0]            cur_preset;
   logic [DWELL_BITS-1:0] cur_dwell;
   logic [1:0]            cur_speed;
   pts_tour_state_type    tour_state;

   // Request handshake: hold off only while a finished result is stalled
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Loop mode register
   assign csr_ready    = 1'b1;
   assign loop_mode_in = (csr_valid && csr_ready) ? csr_loop_mode : loop_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         loop_mode_ff <= LOOP_MODE_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         loop_mode_ff <= loop_mode_in;
      end
   end

   // Step writes beyond the table are dropped
   assign wr_en = req_accept && (req_type == REQ_WRITE_STEP) &&
                  (32'(req_step_index) < MAX_STEPS);

   pts_step_table #(
      .MAX_STEPS  (MAX_STEPS),
      .DWELL_BITS (DWELL_BITS),
      .AW         (AW)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (AW'(req_step_index)),
      .wr_preset (req_preset_num),
      .wr_dwell  (DWELL_BITS'(req_dwell_seconds)),
      .wr_speed  (req_move_speed),
      .rd_en     (req_accept),
      .rd_addr   (rd_addr),
      .rd_preset (cur_preset),
      .rd_dwell  (cur_dwell),
      .rd_speed  (cur_speed)
   );

   pts_tour_ctrl #(
      .MAX_STEPS  (MAX_STEPS),
      .DWELL_BITS (DWELL_BITS),
      .AW         (AW),
      .LW         (LW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .req_type   (req_type),
      .step_count (req_step_count),
      .loop_mode  (loop_mode_ff),
      .cur_dwell  (cur_dwell),
      .rd_addr    (rd_addr),
      .tour_state (tour_state)
   );

   // Result fields; move fields read zero without a trigger
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_trigger      = tour_state.trigger;
   assign rsp_trig_preset  = tour_state.trigger ? cur_preset : 8'd0;
   assign rsp_trig_speed   = tour_state.trigger ? cur_speed : 2'd0;
   assign rsp_roll_rate    = tour_state.trigger ? pts_roll_rate(cur_speed) : 6'd0;
   assign rsp_pitch_rate   = tour_state.trigger ? pts_pitch_rate(cur_speed) : 7'd0;
   assign rsp_yaw_rate     = tour_state.trigger ? pts_yaw_rate(cur_speed) : 7'd0;
   assign rsp_running      = tour_state.running;
   assign rsp_current_step = tour_state.current_step;
   assign rsp_elapsed_s    = tour_state.elapsed_s;
   assign rsp_total_s      = tour_state.running ? 16'(cur_dwell) : 16'd0;
   assign rsp_status       = tour_state.status;

   // A move is only issued on a running tour
   a_trigger_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trigger |-> rsp_running)
      else $error("move issued while tour not running");

   // A refused start leaves the tour stopped and issues no move
   a_status_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_running && !rsp_trigger)
      else $error("refused start with tour running or move issued");

   // Requests are held off only behind a pending result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no pending result");

   // Tour state moves only when a request transaction is taken
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(rsp_elapsed_s) && $stable(rsp_running))
      else $error("tour state changed without a request transaction");

endmodule

### src/pts_step_table.sv
// Step table memory: one write port, one registered read port with write forwarding.
module pts_step_table #(
   parameter int MAX_STEPS  = 16,
   parameter int DWELL_BITS = 16,
   parameter int AW         = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [7:0]            wr_preset,
   input  logic [DWELL_BITS-1:0] wr_dwell,
   input  logic [1:0]            wr_speed,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [7:0]            rd_preset,
   output logic [DWELL_BITS-1:0] rd_dwell,
   output logic [1:0]            rd_speed
);
   import pts_pkg::*;

   logic [7:0]            preset_mem [MAX_STEPS];
   logic [DWELL_BITS-1:0] dwell_mem  [MAX_STEPS];
   logic [1:0]            speed_mem  [MAX_STEPS];

   logic [7:0]            rd_preset_ff;
   logic [DWELL_BITS-1:0] rd_dwell_ff;
   logic [1:0]            rd_speed_ff;
   logic                  fwd;

   // Entries are written only by write-step transactions
   always_ff @(posedge clock) begin
      if (wr_en) begin
         preset_mem[wr_addr] <= wr_preset;
         dwell_mem[wr_addr]  <= wr_dwell;
         speed_mem[wr_addr]  <= wr_speed;
      end
   end

   // Same-cycle write to the read address is returned as new data
   assign fwd = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (fwd) begin
            rd_preset_ff <= wr_preset;
            rd_dwell_ff  <= wr_dwell;
            rd_speed_ff  <= wr_speed;
         end else begin
            rd_preset_ff <= preset_mem[rd_addr];
            rd_dwell_ff  <= dwell_mem[rd_addr];
            rd_speed_ff  <= speed_mem[rd_addr];
         end
      end
   end

   assign rd_preset = rd_preset_ff;
   assign rd_dwell  = rd_dwell_ff;
   assign rd_speed  = rd_speed_ff;

endmodule

### src/pts_tour_ctrl.sv
// Tour control: list length, pointer, direction and seconds counter with next-step logic.
module pts_tour_ctrl #(
   parameter int MAX_STEPS  = 16,
   parameter int DWELL_BITS = 16,
   parameter int AW         = 4,
   parameter int LW         = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [2:0]                  req_type,
   input  logic [4:0]                  step_count,
   input  logic [1:0]                  loop_mode,
   input  logic [DWELL_BITS-1:0]       cur_dwell,
   output logic [AW-1:0]               rd_addr,
   output pts_pkg::pts_tour_state_type tour_state
);
   import pts_pkg::*;

   localparam int CW = (DWELL_BITS > 16) ? DWELL_BITS : 16;
   localparam int PW = LW + 1;

   logic [LW-1:0] length_ff,  length_in;
   logic          active_ff,  active_in;
   logic [AW-1:0] pointer_ff, pointer_in;
   logic          down_ff,    down_in;
   logic [15:0]   seconds_ff, seconds_in;
   logic          trigger_ff, trigger_in;
   logic          status_ff,  status_in;

   logic [LW-1:0] new_len;
   logic [15:0]   sec_inc;
   logic          at_end;
   logic          dwell_done;

   // Saturated length for a set-length transaction
   always_comb begin
      if (32'(step_count) > MAX_STEPS) begin
         new_len = LW'(MAX_STEPS);
      end else begin
         new_len = LW'(step_count);
      end
   end

   assign sec_inc    = (seconds_ff == SEC_MAX) ? seconds_ff : seconds_ff + 16'd1;
   assign dwell_done = CW'(sec_inc) >= CW'(cur_dwell);
   assign at_end     = (PW'(pointer_ff) + PW'(1)) >= PW'(length_ff);

   // Next state for one transaction
   always_comb begin
      length_in  = length_ff;
      active_in  = active_ff;
      pointer_in = pointer_ff;
      down_in    = down_ff;
      seconds_in = seconds_ff;
      trigger_in = 1'b0;
      status_in  = 1'b0;
      case (req_type)
         REQ_SET_LENGTH: begin
            length_in = new_len;
            if (active_ff) begin
               if (new_len == '0) begin
                  active_in  = 1'b0;
                  seconds_in = '0;
               end else if (PW'(pointer_ff) >= PW'(new_len)) begin
                  pointer_in = AW'(new_len - LW'(1));
               end
            end
         end
         REQ_START: begin
            if (!active_ff) begin
               if (length_ff == '0) begin
                  status_in = 1'b1;
               end else begin
                  active_in  = 1'b1;
                  pointer_in = '0;
                  down_in    = 1'b0;
                  seconds_in = '0;
                  trigger_in = 1'b1;
               end
            end
         end
         REQ_STOP: begin
            active_in  = 1'b0;
            seconds_in = '0;
         end
         REQ_TICK: begin
            if (active_ff) begin
               seconds_in = sec_inc;
               if (dwell_done) begin
                  seconds_in = '0;
                  trigger_in = 1'b1;
                  case (loop_mode)
                     MODE_ONCE: begin
                        if (at_end) begin
                           active_in  = 1'b0;
                           trigger_in = 1'b0;
                        end else begin
                           pointer_in = pointer_ff + AW'(1);
                        end
                     end
                     MODE_PINGPONG: begin
                        if (length_ff <= LW'(1)) begin
                           pointer_in = '0;
                        end else if (!down_ff) begin
                           if (at_end) begin
                              down_in    = 1'b1;
                              pointer_in = pointer_ff - AW'(1);
                           end else begin
                              pointer_in = pointer_ff + AW'(1);
                           end
                        end else if (pointer_ff == '0) begin
                           down_in    = 1'b0;
                           pointer_in = AW'(1);
                        end else begin
                           pointer_in = pointer_ff - AW'(1);
                        end
                     end
                     default: begin
                        pointer_in = at_end ? '0 : pointer_ff + AW'(1);
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff  <= '0;
         active_ff  <= 1'b0;
         pointer_ff <= '0;
         down_ff    <= 1'b0;
         seconds_ff <= '0;
         trigger_ff <= 1'b0;
         status_ff  <= 1'b0;
      end else if (accept) begin
         length_ff  <= length_in;
         active_ff  <= active_in;
         pointer_ff <= pointer_in;
         down_ff    <= down_in;
         seconds_ff <= seconds_in;
         trigger_ff <= trigger_in;
         status_ff  <= status_in;
      end
   end

   // Table is read at the step that is current after this transaction
   assign rd_addr = pointer_in;

   always_comb begin
      tour_state.trigger      = trigger_ff;
      tour_state.status       = status_ff;
      tour_state.running      = active_ff;
      tour_state.current_step = active_ff ? 4'(pointer_ff) : 4'd0;
      tour_state.elapsed_s    = active_ff ? seconds_ff : 16'd0;
   end

endmodule

### tb/tb_preset_tour_sequencer_core.sv
// Self-checking testbench for the preset tour sequencer core.
module tb_preset_tour_sequencer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import pts_pkg::*;

   localparam int          TOUR_STEPS      = 16;
   localparam int          IDLE_LIMIT      = 4000;
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam int          MAX_REPORTS     = 10;
   localparam int          ITEMS_PER_MODE  = 350;
   localparam logic [2:0]  REQ_UNDEF_FIRST = 3'd5;
   localparam logic [2:0]  REQ_UNDEF_LAST  = 3'd7;
   localparam logic [1:0]  MODE_UNDEF      = 2'd3;

   // Axis rates per speed code: slow, medium, fast, instant
   localparam logic [5:0] ROLL_BY_SPEED  [4] = '{6'd10, 6'd30, 6'd60, 6'd0};
   localparam logic [6:0] PITCH_BY_SPEED [4] = '{7'd15, 7'd40, 7'd80, 7'd0};
   localparam logic [6:0] YAW_BY_SPEED   [4] = '{7'd20, 7'd60, 7'd120, 7'd0};

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  step_index;
      logic [7:0]  preset_num;
      logic [15:0] dwell_seconds;
      logic [1:0]  move_speed;
      logic [4:0]  step_count;
   } tour_request_type;

   typedef struct packed {
      logic        trigger;
      logic [7:0]  trig_preset;
      logic [1:0]  trig_speed;
      logic [5:0]  roll_rate;
      logic [6:0]  pitch_rate;
      logic [6:0]  yaw_rate;
      logic        running;
      logic [3:0]  current_step;
      logic [15:0] elapsed_s;
      logic [15:0] total_s;
      logic        status;
   } tour_result_type;

   typedef struct packed {
      logic [7:0]  preset;
      logic [15:0] dwell;
      logic [1:0]  speed;
   } tour_entry_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   // Tour state mirror plus the queue of results the block still owes
   class tour_scoreboard_type;
      tour_entry_type  steps [TOUR_STEPS];
      int              list_len;
      bit              active;
      int              pointer;
      bit              descending;
      logic [15:0]     seconds;
      logic [1:0]      loop_mode;
      tour_result_type pending_results [$];
      int unsigned     errors, checked, accepted, moves, refusals;

      function new();
         foreach (steps[i]) steps[i] = '0;
         list_len   = 0;
         active     = 0;
         pointer    = 0;
         descending = 0;
         seconds    = '0;
         loop_mode  = LOOP_MODE_RESET;
         errors     = 0;
         checked    = 0;
         accepted   = 0;
         moves      = 0;
         refusals   = 0;
      endfunction

      function void set_loop_mode(logic [1:0] mode);
         loop_mode = mode;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      function tour_result_type with_move(tour_result_type res, int idx);
         tour_entry_type ent;
         ent = steps[idx];
         res.trigger     = 1'b1;
         res.trig_preset = ent.preset;
         res.trig_speed  = ent.speed;
         res.roll_rate   = ROLL_BY_SPEED[ent.speed];
         res.pitch_rate  = PITCH_BY_SPEED[ent.speed];
         res.yaw_rate    = YAW_BY_SPEED[ent.speed];
         return res;
      endfunction

      // Step after idx for the loop mode; once mode ends the tour at the last step
      function int next_index(int idx, int n);
         case (loop_mode)
            MODE_ONCE: begin
               if (idx + 1 >= n) begin
                  active = 0;
                  return idx;
               end
               return idx + 1;
            end
            MODE_PINGPONG: begin
               if (n <= 1) return 0;
               if (!descending) begin
                  if (idx + 1 >= n) begin
                     descending = 1;
                     return idx - 1;
                  end
                  return idx + 1;
               end
               if (idx == 0) begin
                  descending = 0;
                  return 1;
               end
               return idx - 1;
            end
            default: return (idx + 1 >= n) ? 0 : idx + 1;
         endcase
      endfunction

      // Apply one accepted request transaction and queue the result it owes
      function void note_request(tour_request_type req);
         tour_result_type res;
         int n, nx;
         res = '0;
         accepted++;
         case (req.kind)
            REQ_WRITE_STEP: begin
               steps[req.step_index] = '{preset: req.preset_num, dwell: req.dwell_seconds,
                                         speed: req.move_speed};
            end
            REQ_SET_LENGTH: begin
               n = (req.step_count > TOUR_STEPS) ? TOUR_STEPS : int'(req.step_count);
               list_len = n;
               if (active) begin
                  if (n == 0) begin
                     active  = 0;
                     seconds = '0;
                  end else if (pointer >= n) begin
                     pointer = n - 1;
                  end
               end
            end
            REQ_START: begin
               if (!active) begin
                  if (list_len == 0) begin
                     res.status = 1'b1;
                     refusals++;
                  end else begin
                     active     = 1;
                     pointer    = 0;
                     descending = 0;
                     seconds    = '0;
                     res        = with_move(res, 0);
                  end
               end
            end
            REQ_STOP: begin
               active  = 0;
               seconds = '0;
            end
            REQ_TICK: begin
               if (active) begin
                  if (seconds != SEC_MAX) seconds++;
                  if (seconds >= steps[pointer].dwell) begin
                     nx      = next_index(pointer, list_len);
                     seconds = '0;
                     if (active) begin
                        pointer = nx;
                        res     = with_move(res, nx);
                     end
                  end
               end
            end
            default: ;
         endcase
         res.running = active;
         if (active) begin
            res.current_step = 4'(pointer);
            res.elapsed_s    = seconds;
            res.total_s      = steps[pointer].dwell;
         end
         if (res.trigger) moves++;
         pending_results = {pending_results, res};
      endfunction

      function string describe(tour_result_type r);
         return $sformatf({"trig=%0d preset=%0d speed=%0d rates=%0d/%0d/%0d run=%0d ",
                           "step=%0d elapsed=%0d total=%0d status=%0d"},
                          r.trigger, r.trig_preset, r.trig_speed, r.roll_rate,
                          r.pitch_rate, r.yaw_rate, r.running, r.current_step,
                          r.elapsed_s, r.total_s, r.status);
      endfunction

      // Compare one result transaction with the oldest outstanding prediction
      function void check_result(tour_result_type got);
         tour_result_type want;
         checked++;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("ERROR: result %0d arrived with nothing outstanding: %s",
                        checked, describe(got));
            return;
         end
         want = pending_results[0];
         pending_results.delete(0);
         if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("ERROR: result %0d expected %s", checked, describe(want));
               $display("       result %0d actual   %s", checked, describe(got));
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_type;
   logic [3:0]  req_step_index;
   logic [7:0]  req_preset_num;
   logic [15:0] req_dwell_seconds;
   logic [1:0]  req_move_speed;
   logic [4:0]  req_step_count;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_trigger;
   logic [7:0]  rsp_trig_preset;
   logic [1:0]  rsp_trig_speed;
   logic [5:0]  rsp_roll_rate;
   logic [6:0]  rsp_pitch_rate;
   logic [6:0]  rsp_yaw_rate;
   logic        rsp_running;
   logic [3:0]  rsp_current_step;
   logic [15:0] rsp_elapsed_s;
   logic [15:0] rsp_total_s;
   logic        rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_loop_mode;

   tour_scoreboard_type sb;
   tour_result_type     observed;
   bit                  no_gaps        = 0;
   bit                  hold_off_start = 0;
   int unsigned         burst_left     = 0;
   int unsigned         hold_left      = 0;
   int unsigned         pattern_left   = 0;
   int unsigned         idle_cycles    = 0;
   stall_style_type     stall_style    = STALL_NONE;

   preset_tour_sequencer_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_step_index    (req_step_index),
      .req_preset_num    (req_preset_num),
      .req_dwell_seconds (req_dwell_seconds),
      .req_move_speed    (req_move_speed),
      .req_step_count    (req_step_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_trigger       (rsp_trigger),
      .rsp_trig_preset   (rsp_trig_preset),
      .rsp_trig_speed    (rsp_trig_speed),
      .rsp_roll_rate     (rsp_roll_rate),
      .rsp_pitch_rate    (rsp_pitch_rate),
      .rsp_yaw_rate      (rsp_yaw_rate),
      .rsp_running       (rsp_running),
      .rsp_current_step  (rsp_current_step),
      .rsp_elapsed_s     (rsp_elapsed_s),
      .rsp_total_s       (rsp_total_s),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_loop_mode     (csr_loop_mode)
   );

   always #10 clock = ~clock;

   assign observed = {rsp_trigger, rsp_trig_preset, rsp_trig_speed, rsp_roll_rate,
                      rsp_pitch_rate, rsp_yaw_rate, rsp_running, rsp_current_step,
                      rsp_elapsed_s, rsp_total_s, rsp_status};

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(observed);
   end

   // Receiver stall pattern, with an occasional long hold-off on request
   always @(posedge clock) begin
      if (hold_off_start) begin
         hold_left      = HOLD_OFF_CYCLES;
         hold_off_start = 0;
      end
      if (pattern_left == 0) begin
         stall_style  = stall_style_type'($urandom_range(0, 3));
         pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_style)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 30);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 70);
            default:     rsp_stall <= (pattern_left % 3 == 0);
         endcase
      end
   end

   // Watchdog: too long without any transaction on any channel
   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                     (csr_valid && csr_ready)))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   function automatic tour_request_type make_request(logic [2:0] kind, logic [3:0] idx,
                                                     logic [7:0] preset, logic [15:0] dwell,
                                                     logic [1:0] speed, logic [4:0] count);
      return '{kind: kind, step_index: idx, preset_num: preset, dwell_seconds: dwell,
               move_speed: speed, step_count: count};
   endfunction

   // Mostly well-formed tours: short lists, small dwells, plenty of ticks
   function automatic tour_request_type random_request();
      tour_request_type r;
      int unsigned      pick;
      r.step_index    = 4'($urandom_range(0, TOUR_STEPS - 1));
      r.preset_num    = 8'($urandom);
      r.dwell_seconds = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 3));
      r.move_speed    = 2'($urandom);
      r.step_count    = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(1, 5));
      pick = $urandom_range(0, 99);
      if (pick < 55)      r.kind = REQ_TICK;
      else if (pick < 70) r.kind = REQ_WRITE_STEP;
      else if (pick < 80) r.kind = REQ_SET_LENGTH;
      else if (pick < 89) r.kind = REQ_START;
      else if (pick < 96) r.kind = REQ_STOP;
      else                r.kind = 3'($urandom_range(REQ_UNDEF_FIRST, REQ_UNDEF_LAST));
      return r;
   endfunction

   // Offer one request transaction, in bursts separated by random gaps
   task automatic send_request(input tour_request_type r);
      int unsigned gap;
      if (!no_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_valid         <= 1'b1;
      req_type          <= r.kind;
      req_step_index    <= r.step_index;
      req_preset_num    <= r.preset_num;
      req_dwell_seconds <= r.dwell_seconds;
      req_move_speed    <= r.move_speed;
      req_step_count    <= r.step_count;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   // Stop offering and wait until every outstanding result is back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_loop_mode(input logic [1:0] mode);
      csr_valid     <= 1'b1;
      csr_loop_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      sb.set_loop_mode(mode);
      csr_valid <= 1'b0;
   endtask

   // Short fixed tour at the head of each mode: reaches the end of the list
   task automatic open_phase(input logic [1:0] mode);
      send_request(make_request(REQ_WRITE_STEP, 4'd0, 8'($urandom), 16'd0, 2'($urandom),
                                5'd0));
      send_request(make_request(REQ_WRITE_STEP, 4'd1, 8'($urandom), 16'd1, 2'($urandom),
                                5'd0));
      send_request(make_request(REQ_SET_LENGTH, 4'd0, 8'd0, 16'd0, SPEED_SLOW,
                                (mode == MODE_PINGPONG) ? 5'd1 : 5'd2));
      send_request(make_request(REQ_STOP, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
      send_request(make_request(REQ_START, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
      repeat (4) send_request(make_request(REQ_TICK, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
   endtask

   initial begin
      logic [1:0] mode_order [4];
      mode_order = '{MODE_ONCE, MODE_PINGPONG, MODE_UNDEF, MODE_WRAP};
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_type          <= REQ_TICK;
      req_step_index    <= '0;
      req_preset_num    <= '0;
      req_dwell_seconds <= '0;
      req_move_speed    <= SPEED_SLOW;
      req_step_count    <= '0;
      rsp_stall         <= 1'b0;
      csr_valid         <= 1'b0;
      csr_loop_mode     <= LOOP_MODE_RESET;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle-state corner cases before the list has any length
      send_request(make_request(REQ_START, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
      send_request(make_request(REQ_STOP, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
      send_request(make_request(REQ_TICK, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
      send_request(make_request(REQ_UNDEF_LAST, 4'hF, 8'hFF, 16'hFFFF, SPEED_INSTANT,
                                5'd31));
      // Fill the whole table so no unwritten entry ever reaches a result
      for (int i = 0; i < TOUR_STEPS; i++)
         send_request(make_request(REQ_WRITE_STEP, 4'(i), 8'(i * 17),
                                   (i == TOUR_STEPS - 1) ? SEC_MAX : 16'(i % 3),
                                   2'(i % 4), 5'd0));
      // Oversized length, start twice, moves, rewrite of the live step, shrink, empty
      send_request(make_request(REQ_SET_LENGTH, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd31));
      send_request(make_request(REQ_START, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
      send_request(make_request(REQ_START, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
      repeat (3) send_request(make_request(REQ_TICK, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
      send_request(make_request(REQ_WRITE_STEP, 4'd2, 8'hAA, 16'd1, SPEED_INSTANT, 5'd0));
      send_request(make_request(REQ_TICK, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
      send_request(make_request(REQ_SET_LENGTH, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd2));
      send_request(make_request(REQ_SET_LENGTH, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
      drain();

      // Random phases, one per loop mode
      foreach (mode_order[m]) begin
         write_loop_mode(mode_order[m]);
         open_phase(mode_order[m]);
         repeat (ITEMS_PER_MODE) send_request(random_request());
         if (mode_order[m] == MODE_WRAP) begin
            // Long result hold-off while requests keep coming
            hold_off_start = 1;
            no_gaps        = 1;
            repeat (40) send_request(random_request());
            // Single step with the longest dwell: elapsed count climbs with no move
            send_request(make_request(REQ_WRITE_STEP, 4'd0, 8'hFF, SEC_MAX, SPEED_INSTANT,
                                      5'd0));
            send_request(make_request(REQ_SET_LENGTH, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd1));
            send_request(make_request(REQ_STOP, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
            send_request(make_request(REQ_START, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
            repeat (24)
               send_request(make_request(REQ_TICK, 4'd0, 8'd0, 16'd0, SPEED_SLOW, 5'd0));
            no_gaps = 0;
         end
         drain();
      end

      repeat (4) @(posedge clock);
      $display("Run covered %0d requests and %0d results: %0d preset moves, %0d refused starts.",
               sb.accepted, sb.checked, sb.moves, sb.refusals);
      $display("Loop modes once, wrap, ping-pong and the unused code; long hold-off; %s",
               "a long dwell counted up without a move.");
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
